@@ hw/rtl/cdad_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cdad_pkg;

   // Widths of the request and response fields.
   localparam int unsigned START_YEAR_W = 14;
   localparam int unsigned MONTH_W      = 4;
   localparam int unsigned DAY_W        = 5;
   localparam int unsigned DAYS_W       = 16;
   localparam int unsigned HOUR_W       = 5;
   localparam int unsigned MINUTE_W     = 6;
   localparam int unsigned SECOND_W     = 6;
   localparam int unsigned WEEKDAY_W    = 3;

   // Width of a remainder from the shared divider (below one century).
   localparam int unsigned REM_W = 7;

   // Calendar codes.
   localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
   localparam logic [MONTH_W-1:0] MARCH    = 4'd3;
   localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

   localparam logic [REM_W:0]   CENTURY_DIVISOR = 8'd100;
   localparam logic [REM_W:0]   WEEK_DIVISOR    = 8'd7;
   localparam logic [REM_W-1:0] LAST_OF_CENTURY = 7'd99;
   localparam logic [WEEKDAY_W-1:0] SATURDAY    = 3'd6;
   localparam logic [WEEKDAY_W-1:0] SUNDAY      = 3'd0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // take a new request
      logic div_start;   // start the shared divider
      logic div_by7;     // divider works modulo the week, else by the century
      logic year_split;  // latch year quotient and remainder by 100
      logic walk_step;   // advance the date by one month or to the end
      logic zsum_a;      // first half of the weekday sum
      logic zsum_b;      // second half of the weekday sum
      logic out_load;    // load the response register
      logic out_err;     // response carries an error and echoes the start date
   } cdad_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic early_bad;   // year zero, year above the maximum, or month out of range
      logic day_bad;     // day of month out of range
      logic walk_done;   // no days left to add
      logic walk_ovf;    // the next step would pass the maximum year
      logic div_done;    // divider result is ready
   } cdad_sts_type;

   // Length of a month, with February stretched in a leap year.
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      begin
         unique case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
         endcase
         return len;
      end
   endfunction

   // Month term of Zeller's congruence, floor(13 * (m + 1) / 5), where January
   // and February count as months 13 and 14 of the previous year.
   function automatic logic [5:0] zeller_month_term(input logic [MONTH_W-1:0] month);
      logic [5:0] term;
      begin
         unique case (month)
            4'd1:    term = 6'd36;
            4'd2:    term = 6'd39;
            4'd3:    term = 6'd10;
            4'd4:    term = 6'd13;
            4'd5:    term = 6'd15;
            4'd6:    term = 6'd18;
            4'd7:    term = 6'd20;
            4'd8:    term = 6'd23;
            4'd9:    term = 6'd26;
            4'd10:   term = 6'd28;
            4'd11:   term = 6'd31;
            4'd12:   term = 6'd33;
            default: term = 6'd0;
         endcase
         return term;
      end
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cdad_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Division by a fixed divisor of 100 or 7 through a multiply by the rounded-up
// reciprocal. The quotient is registered at start and the remainder in the next
// cycle, when done rises. The result is exact for a dividend below 2^17 by 100
// and below 2^15 by 7.
module cdad_div
   import cdad_pkg::*;
#(
   parameter int unsigned W = 14
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                by7,
   input  logic [W-1:0]        dividend,
   output logic                done,
   output logic [W-1:0]        quot,
   output logic [REM_W-1:0]    remainder
);

   localparam int unsigned RECIP_W = 18;
   localparam int unsigned PW      = W + RECIP_W;

   // Reciprocals rounded up: 2^24 / 100 and 2^17 / 7.
   localparam logic [RECIP_W-1:0] RECIP_CENTURY = 18'd167773;
   localparam logic [RECIP_W-1:0] RECIP_WEEK    = 18'd18725;
   localparam int unsigned        SHIFT_CENTURY = 24;
   localparam int unsigned        SHIFT_WEEK    = 17;

   logic             busy_ff;
   logic             done_ff;
   logic             by7_ff;
   logic [W-1:0]     x_ff;
   logic [W-1:0]     quot_ff;
   logic [REM_W-1:0] rem_ff;

   logic [PW-1:0]    product;
   logic [W-1:0]     quot_in;
   logic [REM_W:0]   divisor;
   logic [W-1:0]     back;
   logic [W-1:0]     diff;

   // Quotient from the scaled reciprocal.
   always_comb begin
      product = PW'(dividend) * PW'(by7 ? RECIP_WEEK : RECIP_CENTURY);
      quot_in = by7 ? W'(product >> SHIFT_WEEK) : W'(product >> SHIFT_CENTURY);
   end

   // Remainder from the registered quotient; it is below one century, so the
   // low bits of the difference are enough.
   always_comb begin
      divisor = by7_ff ? WEEK_DIVISOR : CENTURY_DIVISOR;
      back    = quot_ff * W'(divisor);
      diff    = x_ff - back;
   end

   // Busy and done pulses.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= start;
         done_ff <= busy_ff;
      end
   end

   // Operand, quotient and remainder registers.
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= dividend;
         by7_ff  <= by7;
         quot_ff <= quot_in;
      end
      if (busy_ff) begin
         rem_ff <= diff[REM_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quot      = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ hw/rtl/cdad_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cdad_datapath
   import cdad_pkg::*;
#(
   parameter int unsigned MAX_YEAR = 9999,
   parameter int unsigned YEAR_W   = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cdad_cmd_type            cmd,
   output cdad_sts_type            sts,
   input  logic [START_YEAR_W-1:0] start_year,
   input  logic [MONTH_W-1:0]      start_month,
   input  logic [DAY_W-1:0]        start_day,
   input  logic [DAYS_W-1:0]       days_to_add,
   input  logic [HOUR_W-1:0]       hour_in,
   input  logic [MINUTE_W-1:0]     minute_in,
   input  logic [SECOND_W-1:0]     second_in,
   output logic [START_YEAR_W-1:0] result_year,
   output logic [MONTH_W-1:0]      result_month,
   output logic [DAY_W-1:0]        result_day,
   output logic [WEEKDAY_W-1:0]    weekday,
   output logic [HOUR_W-1:0]       hour_out,
   output logic [MINUTE_W-1:0]     minute_out,
   output logic [SECOND_W-1:0]     second_out,
   output logic                    date_error
);

   // Centuries need six bits fewer than years; the weekday sum three fewer.
   localparam int unsigned QW = YEAR_W - 6;
   localparam int unsigned SW = YEAR_W - 3;
   localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);

   // Captured request.
   logic [START_YEAR_W-1:0] sy_ff;
   logic [MONTH_W-1:0]      sm_ff;
   logic [DAY_W-1:0]        sd_ff;
   logic [HOUR_W-1:0]       hour_ff;
   logic [MINUTE_W-1:0]     minute_ff;
   logic [SECOND_W-1:0]     second_ff;

   // Running date and days still to add.
   logic [YEAR_W-1:0]       ry_ff;
   logic [MONTH_W-1:0]      rm_ff;
   logic [DAY_W-1:0]        rd_ff;
   logic [DAYS_W-1:0]       rem_ff;
   logic [REM_W-1:0]        r100_ff;
   logic [QW-1:0]           q100_ff;

   // Weekday sum.
   logic [7:0]              part_ff;
   logic [SW-1:0]           sum_ff;

   // Response register.
   logic [START_YEAR_W-1:0] oyear_ff;
   logic [MONTH_W-1:0]      omonth_ff;
   logic [DAY_W-1:0]        oday_ff;
   logic [WEEKDAY_W-1:0]    owday_ff;
   logic [HOUR_W-1:0]       ohour_ff;
   logic [MINUTE_W-1:0]     ominute_ff;
   logic [SECOND_W-1:0]     osecond_ff;
   logic                    oerr_ff;

   logic [YEAR_W-1:0]       sy_ext;
   logic                    leap;
   logic [DAY_W-1:0]        md;
   logic [DAYS_W:0]         reach;
   logic                    fits;
   logic [DAY_W:0]          consumed;
   logic [REM_W-1:0]        kval;
   logic [QW-1:0]           jval;
   logic [YEAR_W-1:0]       div_dividend;
   logic                    div_done;
   logic [YEAR_W-1:0]       div_quot;
   logic [REM_W-1:0]        div_rem;
   logic [WEEKDAY_W-1:0]    wday;

   assign sy_ext = YEAR_W'(sy_ff);

   // Leap year from the year split by 100: divisible by 4 unless a century,
   // then the century count must be divisible by 4.
   always_comb begin
      leap     = (r100_ff != '0) ? (r100_ff[1:0] == 2'b00) : (q100_ff[1:0] == 2'b00);
      md       = month_days(rm_ff, leap);
      reach    = (DAYS_W + 1)'(rd_ff) + (DAYS_W + 1)'(rem_ff);
      fits     = (reach <= (DAYS_W + 1)'(md));
      consumed = (DAY_W + 1)'(md) - (DAY_W + 1)'(rd_ff) + (DAY_W + 1)'(1);
   end

   // Zeller year terms; January and February belong to the previous year.
   always_comb begin
      if (rm_ff < MARCH) begin
         if (r100_ff == '0) begin
            kval = LAST_OF_CENTURY;
            jval = q100_ff - 1'b1;
         end else begin
            kval = r100_ff - 1'b1;
            jval = q100_ff;
         end
      end else begin
         kval = r100_ff;
         jval = q100_ff;
      end
   end

   // Status for the controller.
   always_comb begin
      sts.early_bad = (sy_ff == '0) || (sy_ext > MAX_Y) ||
                      (sm_ff == '0) || (sm_ff > DECEMBER);
      sts.day_bad   = (sd_ff == '0) || (sd_ff > month_days(sm_ff, leap));
      sts.walk_done = (rem_ff == '0);
      sts.walk_ovf  = !fits && (rm_ff == DECEMBER) && (ry_ff >= MAX_Y);
      sts.div_done  = div_done;
   end

   // Shared divider: the start year by 100, later the weekday sum by 7.
   assign div_dividend = cmd.div_by7 ? YEAR_W'(sum_ff) : sy_ext;

   cdad_div #(
      .W (YEAR_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .by7       (cmd.div_by7),
      .dividend  (div_dividend),
      .done      (div_done),
      .quot      (div_quot),
      .remainder (div_rem)
   );

   // Zeller gives 0 for Saturday; shift so that 0 is Sunday.
   assign wday = (div_rem[WEEKDAY_W-1:0] == SUNDAY) ? SATURDAY
                                                    : div_rem[WEEKDAY_W-1:0] - 1'b1;

   // Request capture, the year split and the month-by-month walk.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sy_ff     <= start_year;
         sm_ff     <= start_month;
         sd_ff     <= start_day;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         ry_ff     <= YEAR_W'(start_year);
         rm_ff     <= start_month;
         rd_ff     <= start_day;
         rem_ff    <= days_to_add;
      end else if (cmd.year_split) begin
         q100_ff <= div_quot[QW-1:0];
         r100_ff <= div_rem;
      end else if (cmd.walk_step) begin
         if (fits) begin
            rd_ff  <= rd_ff + rem_ff[DAY_W-1:0];
            rem_ff <= '0;
         end else begin
            rem_ff <= rem_ff - DAYS_W'(consumed);
            rd_ff  <= DAY_W'(1);
            if (rm_ff == DECEMBER) begin
               rm_ff <= JANUARY;
               ry_ff <= ry_ff + 1'b1;
               if (r100_ff == LAST_OF_CENTURY) begin
                  r100_ff <= '0;
                  q100_ff <= q100_ff + 1'b1;
               end else begin
                  r100_ff <= r100_ff + 1'b1;
               end
            end else begin
               rm_ff <= rm_ff + 1'b1;
            end
         end
      end
   end

   // Weekday sum in two halves.
   always_ff @(posedge clock) begin
      if (cmd.zsum_a) begin
         part_ff <= 8'(rd_ff) + 8'(zeller_month_term(rm_ff)) + 8'(kval) + 8'(kval >> 2);
      end
      if (cmd.zsum_b) begin
         sum_ff <= SW'(part_ff) + SW'(jval >> 2) + SW'({jval, 2'b00}) + SW'(jval);
      end
   end

   // Response register; an error echoes the start date.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ohour_ff   <= hour_ff;
         ominute_ff <= minute_ff;
         osecond_ff <= second_ff;
         oerr_ff    <= cmd.out_err;
         if (cmd.out_err) begin
            oyear_ff  <= sy_ff;
            omonth_ff <= sm_ff;
            oday_ff   <= sd_ff;
            owday_ff  <= SUNDAY;
         end else begin
            oyear_ff  <= ry_ff[START_YEAR_W-1:0];
            omonth_ff <= rm_ff;
            oday_ff   <= rd_ff;
            owday_ff  <= wday;
         end
      end
   end

   assign result_year  = oyear_ff;
   assign result_month = omonth_ff;
   assign result_day   = oday_ff;
   assign weekday      = owday_ff;
   assign hour_out     = ohour_ff;
   assign minute_out   = ominute_ff;
   assign second_out   = osecond_ff;
   assign date_error   = oerr_ff;

`ifndef SYNTHESIS
   // Every walk step uses up at least one day.
   a_walk_progress: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |=> (rem_ff < $past(rem_ff)))
      else $error("walk step did not reduce the remaining days");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/cdad_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cdad_ctrl
   import cdad_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output cdad_cmd_type cmd,
   input  cdad_sts_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRECHECK,
      ST_SPLIT,
      ST_DAYCHECK,
      ST_WALK,
      ST_ZSUM_A,
      ST_ZSUM_B,
      ST_DIV7_START,
      ST_DIV7,
      ST_DELIVER
   } state_type;

   state_type state_ff, state_in;
   logic      err_ff, err_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Commands and next state.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      err_in   = err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               err_in      = 1'b0;
               state_in    = ST_PRECHECK;
            end
         end
         ST_PRECHECK: begin
            if (sts.early_bad) begin
               err_in   = 1'b1;
               state_in = ST_DELIVER;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (sts.div_done) begin
               cmd.year_split = 1'b1;
               state_in       = ST_DAYCHECK;
            end
         end
         ST_DAYCHECK: begin
            if (sts.day_bad) begin
               err_in   = 1'b1;
               state_in = ST_DELIVER;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (sts.walk_done) begin
               state_in = ST_ZSUM_A;
            end else if (sts.walk_ovf) begin
               err_in   = 1'b1;
               state_in = ST_DELIVER;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_ZSUM_A: begin
            cmd.zsum_a = 1'b1;
            state_in   = ST_ZSUM_B;
         end
         ST_ZSUM_B: begin
            cmd.zsum_b = 1'b1;
            state_in   = ST_DIV7_START;
         end
         ST_DIV7_START: begin
            cmd.div_start = 1'b1;
            cmd.div_by7   = 1'b1;
            state_in      = ST_DIV7;
         end
         ST_DIV7: begin
            cmd.div_by7 = 1'b1;
            if (sts.div_done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            cmd.out_err = err_ff;
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The response register holds its response until the far side takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hw/rtl/calendar_date_add_days.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Adds a count of days to a Gregorian date and returns the new date, its
// weekday (0 is Sunday) and the time of day passed through unchanged. A start
// date with year zero, a year above MAX_YEAR, a bad month or a bad day, or a
// walk that would pass MAX_YEAR, sets date_error and echoes the start date with
// weekday 0. One request is worked at a time; a new request is taken as soon as
// the previous one has moved into the response register. A valid request makes
// one walk step for each month boundary crossed plus one for a final part month
// (up to about 2155 for 65535 days): the date advances one month per cycle, and
// a reciprocal-multiply divider splits the start year by 100 and later reduces
// the weekday sum modulo 7. A start year or month out of range skips the divider
// and the walk, and a bad day skips the walk and the weekday sum; a stalled
// response holds the block until it is taken.
module calendar_date_add_days
   import cdad_pkg::*;
#(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [START_YEAR_W-1:0] req_start_year,
   input  logic [MONTH_W-1:0]      req_start_month,
   input  logic [DAY_W-1:0]        req_start_day,
   input  logic [DAYS_W-1:0]       req_days_to_add,
   input  logic [HOUR_W-1:0]       req_hour_in,
   input  logic [MINUTE_W-1:0]     req_minute_in,
   input  logic [SECOND_W-1:0]     req_second_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [START_YEAR_W-1:0] rsp_result_year,
   output logic [MONTH_W-1:0]      rsp_result_month,
   output logic [DAY_W-1:0]        rsp_result_day,
   output logic [WEEKDAY_W-1:0]    rsp_weekday,
   output logic [HOUR_W-1:0]       rsp_hour_out,
   output logic [MINUTE_W-1:0]     rsp_minute_out,
   output logic [SECOND_W-1:0]     rsp_second_out,
   output logic                    rsp_date_error
);

   // The running year must reach one past MAX_YEAR and hold any start year.
   localparam int unsigned YEAR_BITS = $clog2(MAX_YEAR + 2);
   localparam int unsigned YEAR_W    = (YEAR_BITS > START_YEAR_W) ? YEAR_BITS : START_YEAR_W;

   cdad_cmd_type cmd;
   cdad_sts_type sts;

   // Sequencer.
   cdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Date arithmetic and response register.
   cdad_datapath #(
      .MAX_YEAR (MAX_YEAR),
      .YEAR_W   (YEAR_W)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .start_year   (req_start_year),
      .start_month  (req_start_month),
      .start_day    (req_start_day),
      .days_to_add  (req_days_to_add),
      .hour_in      (req_hour_in),
      .minute_in    (req_minute_in),
      .second_in    (req_second_in),
      .result_year  (rsp_result_year),
      .result_month (rsp_result_month),
      .result_day   (rsp_result_day),
      .weekday      (rsp_weekday),
      .hour_out     (rsp_hour_out),
      .minute_out   (rsp_minute_out),
      .second_out   (rsp_second_out),
      .date_error   (rsp_date_error)
   );

`ifndef SYNTHESIS
   // Once a request is taken, the block is busy with it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request port open right after a request was taken");

   // A good date response carries a real month, day and weekday.
   a_good_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_date_error) |->
         (rsp_result_month != '0) && (rsp_result_month <= DECEMBER) &&
         (rsp_weekday <= SATURDAY) && (rsp_result_day != '0))
      else $error("response date out of range without error");

   // An error response always has weekday Sunday.
   a_error_weekday: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_date_error) |-> (rsp_weekday == SUNDAY))
      else $error("error response with a weekday");
`endif

endmodule

`default_nettype wire

@@ tb/sv/calendar_date_add_days_tb.sv @@
`timescale 1ns / 1ps

module calendar_date_add_days_tb;
   import cdad_pkg::*;

   localparam int unsigned MAX_YEAR     = 9999;
   localparam int unsigned RANDOM_COUNT = 240;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned SETTLE       = 64;

   // Month codes that the package does not name.
   localparam logic [MONTH_W-1:0] APRIL     = 4'd4;
   localparam logic [MONTH_W-1:0] JUNE      = 4'd6;
   localparam logic [MONTH_W-1:0] SEPTEMBER = 4'd9;
   localparam logic [MONTH_W-1:0] NOVEMBER  = 4'd11;

   typedef struct packed {
      logic [START_YEAR_W-1:0] year;
      logic [MONTH_W-1:0]      month;
      logic [DAY_W-1:0]        day;
      logic [WEEKDAY_W-1:0]    weekday;
      logic [HOUR_W-1:0]       hour;
      logic [MINUTE_W-1:0]     minute;
      logic [SECOND_W-1:0]     second;
      logic                    error;
   } date_result_t;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [START_YEAR_W-1:0] req_start_year;
   logic [MONTH_W-1:0]      req_start_month;
   logic [DAY_W-1:0]        req_start_day;
   logic [DAYS_W-1:0]       req_days_to_add;
   logic [HOUR_W-1:0]       req_hour_in;
   logic [MINUTE_W-1:0]     req_minute_in;
   logic [SECOND_W-1:0]     req_second_in;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [START_YEAR_W-1:0] rsp_result_year;
   logic [MONTH_W-1:0]      rsp_result_month;
   logic [DAY_W-1:0]        rsp_result_day;
   logic [WEEKDAY_W-1:0]    rsp_weekday;
   logic [HOUR_W-1:0]       rsp_hour_out;
   logic [MINUTE_W-1:0]     rsp_minute_out;
   logic [SECOND_W-1:0]     rsp_second_out;
   logic                    rsp_date_error;

   date_result_t expected_dates[$];
   date_result_t want;
   int unsigned  mismatch_count = 0;
   bit           sender_idle    = 1'b1;
   bit           receiver_idle  = 1'b1;
   int unsigned  rsp_hold_left  = 0;
   int unsigned  rsp_gap_left   = 0;

   calendar_date_add_days #(
      .MAX_YEAR(MAX_YEAR)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_year   (req_start_year),
      .req_start_month  (req_start_month),
      .req_start_day    (req_start_day),
      .req_days_to_add  (req_days_to_add),
      .req_hour_in      (req_hour_in),
      .req_minute_in    (req_minute_in),
      .req_second_in    (req_second_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_year  (rsp_result_year),
      .rsp_result_month (rsp_result_month),
      .rsp_result_day   (rsp_result_day),
      .rsp_weekday      (rsp_weekday),
      .rsp_hour_out     (rsp_hour_out),
      .rsp_minute_out   (rsp_minute_out),
      .rsp_second_out   (rsp_second_out),
      .rsp_date_error   (rsp_date_error)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Gregorian leap rule: every fourth year, except centuries not divisible by 400.
   function automatic bit is_leap_year(input int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   function automatic int unsigned month_length(input int unsigned yr, input int unsigned mo);
      if (mo == FEBRUARY) begin
         return is_leap_year(yr) ? 29 : 28;
      end
      if (mo == APRIL || mo == JUNE || mo == SEPTEMBER || mo == NOVEMBER) begin
         return 30;
      end
      return 31;
   endfunction

   // Zeller's congruence, rotated so that Sunday comes out as zero.
   function automatic int unsigned weekday_of_date(input int unsigned yr, input int unsigned mo,
                                                   input int unsigned dy);
      int unsigned k;
      int unsigned j;
      int unsigned h;
      if (mo < MARCH) begin
         mo = mo + 12;
         yr = yr - 1;
      end
      k = yr % 100;
      j = yr / 100;
      h = (dy + (13 * (mo + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
      return (h + 6) % 7;
   endfunction

   // Expected response for one request: walk forward a month at a time.
   function automatic date_result_t add_days_to_date(
      input int unsigned yr0, input int unsigned mo0, input int unsigned dy0,
      input int unsigned days, input int unsigned hr, input int unsigned mi,
      input int unsigned se);
      date_result_t r;
      int unsigned  yr;
      int unsigned  mo;
      int unsigned  dy;
      int unsigned  left;
      int unsigned  len;
      bit           bad;
      yr   = yr0;
      mo   = mo0;
      dy   = dy0;
      left = days;
      bad  = 1'b0;
      if (yr == 0 || yr > MAX_YEAR || mo < JANUARY || mo > DECEMBER) begin
         bad = 1'b1;
      end else if (dy < 1 || dy > month_length(yr, mo)) begin
         bad = 1'b1;
      end
      while (!bad && left > 0) begin
         len = month_length(yr, mo);
         if (dy + left <= len) begin
            dy   = dy + left;
            left = 0;
         end else begin
            left = left - (len - dy + 1);
            dy   = 1;
            mo   = mo + 1;
            if (mo > DECEMBER) begin
               mo = JANUARY;
               yr = yr + 1;
               if (yr > MAX_YEAR) begin
                  bad = 1'b1;
               end
            end
         end
      end
      // A rejected request echoes the start date with a Sunday weekday.
      if (bad) begin
         r.year    = START_YEAR_W'(yr0);
         r.month   = MONTH_W'(mo0);
         r.day     = DAY_W'(dy0);
         r.weekday = SUNDAY;
      end else begin
         r.year    = START_YEAR_W'(yr);
         r.month   = MONTH_W'(mo);
         r.day     = DAY_W'(dy);
         r.weekday = WEEKDAY_W'(weekday_of_date(yr, mo, dy));
      end
      r.hour   = HOUR_W'(hr);
      r.minute = MINUTE_W'(mi);
      r.second = SECOND_W'(se);
      r.error  = bad;
      return r;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned random_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         return 0;
      end
      if (pick < 90) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(10, 60);
   endfunction

   // Offer one request, wait for it to be taken, then maybe go idle for a while.
   task automatic send_date(input int unsigned yr, input int unsigned mo, input int unsigned dy,
                            input int unsigned days, input int unsigned hr,
                            input int unsigned mi, input int unsigned se);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_start_year  <= START_YEAR_W'(yr);
      req_start_month <= MONTH_W'(mo);
      req_start_day   <= DAY_W'(dy);
      req_days_to_add <= DAYS_W'(days);
      req_hour_in     <= HOUR_W'(hr);
      req_minute_in   <= MINUTE_W'(mi);
      req_second_in   <= SECOND_W'(se);
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      expected_dates.push_back(add_days_to_date(yr, mo, dy, days, hr, mi, se));
      gap = sender_idle ? random_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Month and year rollovers, leap days, the longest walks and the year limit.
   task automatic test_calendar_edges();
      send_date(2024, JANUARY, 1, 0, 0, 0, 0);
      send_date(2023, DECEMBER, 31, 1, 23, 59, 59);
      send_date(2024, FEBRUARY, 28, 1, 12, 30, 30);
      send_date(2023, FEBRUARY, 28, 1, 1, 2, 3);
      send_date(1900, FEBRUARY, 28, 1, 4, 5, 6);
      send_date(2000, FEBRUARY, 28, 1, 7, 8, 9);
      send_date(2024, FEBRUARY, 29, 366, 10, 11, 12);
      send_date(1, JANUARY, 1, 65535, 31, 63, 63);
      send_date(MAX_YEAR, DECEMBER, 31, 0, 16, 32, 1);
      send_date(9820, JANUARY, 1, 65535, 8, 16, 32);
      send_date(MAX_YEAR, DECEMBER, 31, 1, 2, 4, 8);
      send_date(MAX_YEAR, JANUARY, 1, 65535, 21, 42, 21);
      send_date(1999, DECEMBER, 31, 0, 0, 63, 0);
   endtask

   // Start dates that must be rejected; time fields still pass through.
   task automatic test_invalid_dates();
      send_date(0, MARCH, 15, 10, 3, 3, 3);
      send_date(MAX_YEAR + 1, JANUARY, 1, 0, 5, 5, 5);
      send_date(16383, 15, 31, 65535, 31, 63, 63);
      send_date(2024, 0, 10, 5, 6, 6, 6);
      send_date(2024, 13, 10, 5, 7, 7, 7);
      send_date(2024, MARCH, 0, 5, 8, 8, 8);
      send_date(2024, APRIL, 31, 5, 9, 9, 9);
      send_date(2023, FEBRUARY, 29, 5, 10, 10, 10);
      send_date(1900, FEBRUARY, 29, 5, 11, 11, 11);
      send_date(2024, FEBRUARY, 30, 5, 12, 12, 12);
      send_date(0, 0, 0, 0, 0, 0, 0);
   endtask

   // Hold the response side off long enough that the block stops taking requests.
   task automatic test_response_backpressure();
      int unsigned i;
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      rsp_hold_left = HOLD_CYCLES;
      for (i = 0; i < 8; i++) begin
         send_date(2024, MARCH, 1 + i, i, i, i, i);
      end
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
   endtask

   // Mostly valid dates with short walks, a share of long walks and dates near the
   // year limit, and the rest raw field noise.
   task automatic test_random_dates();
      int unsigned i;
      int unsigned yr;
      int unsigned mo;
      int unsigned dy;
      int unsigned days;
      for (i = 0; i < RANDOM_COUNT; i++) begin
         if (i % 30 == 0) begin
            sender_idle   = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 99) < 80) begin
            yr   = ($urandom_range(0, 9) == 0) ? $urandom_range(9800, MAX_YEAR)
                                               : $urandom_range(1, MAX_YEAR);
            mo   = $urandom_range(JANUARY, DECEMBER);
            dy   = $urandom_range(1, month_length(yr, mo));
            days = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 1500);
         end else begin
            yr   = $urandom_range(0, 16383);
            mo   = $urandom_range(0, 15);
            dy   = $urandom_range(0, 31);
            days = $urandom_range(0, 65535);
         end
         send_date(yr, mo, dy, days, $urandom_range(0, 31), $urandom_range(0, 63),
                   $urandom_range(0, 63));
      end
      req_valid <= 1'b0;
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
   endtask

   // Response side: a forced hold-off takes priority, otherwise random stalls.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left != 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else if (rsp_gap_left != 0) begin
            rsp_stall <= 1'b1;
            rsp_gap_left--;
         end else begin
            rsp_stall <= 1'b0;
            rsp_gap_left = receiver_idle ? random_gap() : 0;
         end
      end
   end

   // Compare each accepted response with the oldest outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_dates.size() == 0) begin
            $error("response with no request outstanding: year %0d month %0d day %0d",
                   rsp_result_year, rsp_result_month, rsp_result_day);
            mismatch_count++;
         end else begin
            want = expected_dates.pop_front();
            if (rsp_result_year !== want.year) begin
               $error("result_year: expected %0d, actual %0d", want.year, rsp_result_year);
               mismatch_count++;
            end
            if (rsp_result_month !== want.month) begin
               $error("result_month: expected %0d, actual %0d", want.month, rsp_result_month);
               mismatch_count++;
            end
            if (rsp_result_day !== want.day) begin
               $error("result_day: expected %0d, actual %0d", want.day, rsp_result_day);
               mismatch_count++;
            end
            if (rsp_weekday !== want.weekday) begin
               $error("weekday: expected %0d, actual %0d", want.weekday, rsp_weekday);
               mismatch_count++;
            end
            if (rsp_hour_out !== want.hour) begin
               $error("hour_out: expected %0d, actual %0d", want.hour, rsp_hour_out);
               mismatch_count++;
            end
            if (rsp_minute_out !== want.minute) begin
               $error("minute_out: expected %0d, actual %0d", want.minute, rsp_minute_out);
               mismatch_count++;
            end
            if (rsp_second_out !== want.second) begin
               $error("second_out: expected %0d, actual %0d", want.second, rsp_second_out);
               mismatch_count++;
            end
            if (rsp_date_error !== want.error) begin
               $error("date_error: expected %0d, actual %0d", want.error, rsp_date_error);
               mismatch_count++;
            end
         end
      end
   end

   // Overall time limit in case the block hangs.
   initial begin
      #6_000_000;
      $display("calendar_date_add_days regression: fail");
      $finish;
   end

   // Reset, run the tests in turn, drain, and report.
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_start_year  = '0;
      req_start_month = '0;
      req_start_day   = '0;
      req_days_to_add = '0;
      req_hour_in     = '0;
      req_minute_in   = '0;
      req_second_in   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_calendar_edges();
      test_invalid_dates();
      test_response_backpressure();
      test_random_dates();
      while (expected_dates.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("calendar_date_add_days regression: pass");
      end else begin
         $display("calendar_date_add_days regression: fail");
      end
      $finish;
   end

endmodule

@@ calendar_date_add_days.f @@
hw/rtl/cdad_pkg.sv
hw/rtl/cdad_div.sv
hw/rtl/cdad_datapath.sv
hw/rtl/cdad_ctrl.sv
hw/rtl/calendar_date_add_days.sv
tb/sv/calendar_date_add_days_tb.sv
